// File: rtl/core/set_assoc_lru_writeback_cache_tags_assert.svh
// Assertion macros for the cache tag store back end.
`ifndef SET_ASSOC_LRU_WRITEBACK_CACHE_TAGS_ASSERT_SVH
`define SET_ASSOC_LRU_WRITEBACK_CACHE_TAGS_ASSERT_SVH

// Checks a consequence in the same cycle as its cause.
`define SALC_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Checks a consequence in the cycle after its cause.
`define SALC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/salc_pkg.sv
// Shared types, constants and helper functions of the cache tag store.
package salc_pkg;

    localparam int NUM_SETS_DEF = 64;
    localparam int NUM_WAYS_DEF = 4;
    localparam int TAG_BITS_DEF = 20;

    localparam int CMD_W = 2;
    localparam int SET_IN_W = 6;
    localparam int TAG_IN_W = 20;
    localparam int WB_TAG_W = 20;
    localparam int COST_W = 16;
    localparam int CNT_W = 32;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [COST_W-1:0] HIT_TIME_RST = 16'd1;
    localparam logic [COST_W-1:0] MISS_TIME_RST = 16'd100;

    localparam logic REG_HIT_TIME = 1'b0;
    localparam logic REG_MISS_TIME = 1'b1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = 1;

    typedef enum logic [CMD_W-1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_FETCH = 2'd2,
        OP_FILL  = 2'd3
    } op_t;

    typedef struct packed {
        op_t  op;
        logic fill_dirty;
    } cls_t;

    typedef struct packed {
        logic                hit;
        logic                writeback_needed;
        logic [WB_TAG_W-1:0] writeback_tag;
        logic [COST_W-1:0]   access_cost;
        logic [CNT_W-1:0]    hit_count;
        logic [CNT_W-1:0]    miss_count;
        logic [CNT_W-1:0]    clean_evict_count;
        logic [CNT_W-1:0]    dirty_evict_count;
    } res_t;

    typedef enum logic {
        B_IDLE,
        B_EXEC
    } back_state_t;

    function automatic int idx_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

// File: rtl/core/salc_front.sv
// Front stage: accepts input beats, decodes the command and normalizes set and tag.
module salc_front #(
    parameter int NUM_SETS = salc_pkg::NUM_SETS_DEF,
    parameter int TAG_BITS = salc_pkg::TAG_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [salc_pkg::CMD_W-1:0]             s_cmd,
    input  logic [salc_pkg::SET_IN_W-1:0]          s_set_index,
    input  logic [salc_pkg::TAG_IN_W-1:0]          s_tag,
    input  logic                                   s_fill_dirty,
    output logic                                   f_valid,
    input  logic                                   f_ready,
    output salc_pkg::cls_t                         f_cls,
    output logic [salc_pkg::idx_w(NUM_SETS)-1:0]   f_set,
    output logic [TAG_BITS-1:0]                    f_tag
);
    import salc_pkg::*;

    localparam int SET_W = idx_w(NUM_SETS);
    localparam int SET_TAB_N = 2 ** SET_IN_W;
    localparam int TAG_KEEP = (TAG_BITS < TAG_IN_W) ? TAG_BITS : TAG_IN_W;

    logic             valid_reg;
    cls_t             cls_reg;
    logic [SET_W-1:0] set_reg;
    logic [TAG_BITS-1:0] tag_reg;

    logic [SET_W-1:0]    wrap_tab [SET_TAB_N];
    cls_t                cls_next;
    logic [SET_W-1:0]    set_next;
    logic [TAG_BITS-1:0] tag_next;
    logic                accept;

    always_comb begin
        for (int i = 0; i < SET_TAB_N; i++) begin
            wrap_tab[i] = SET_W'(i % NUM_SETS);
        end
        set_next = wrap_tab[s_set_index];
        tag_next = '0;
        for (int b = 0; b < TAG_KEEP; b++) begin
            tag_next[b] = s_tag[b];
        end
        cls_next.op = op_t'(s_cmd);
        cls_next.fill_dirty = s_fill_dirty;
    end

    assign s_ready = !valid_reg || f_ready;
    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (accept) begin
            valid_reg <= 1'b1;
        end else if (f_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cls_reg <= cls_next;
            set_reg <= set_next;
            tag_reg <= tag_next;
        end
    end

    assign f_valid = valid_reg;
    assign f_cls = cls_reg;
    assign f_set = set_reg;
    assign f_tag = tag_reg;

endmodule

// File: rtl/core/salc_queue.sv
// Short queue that decouples the front stage from the tag store back end.
module salc_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    import salc_pkg::*;

    logic [WIDTH-1:0]  buf_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg;
    logic [QPTR_W-1:0] rptr_reg;
    logic [QPTR_W:0]   cnt_reg;
    logic [QPTR_W:0]   cnt_next;
    logic              push;
    logic              pop;

    assign in_ready = cnt_reg != (QPTR_W + 1)'(QUEUE_DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_data = buf_reg[rptr_reg];
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wptr_reg] <= in_data;
        end
    end

endmodule

// File: rtl/core/salc_back.sv
// Back end: tag, valid, dirty and recency store with lookup, fill and counters.
`include "set_assoc_lru_writeback_cache_tags_assert.svh"

module salc_back #(
    parameter int NUM_SETS = salc_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS = salc_pkg::NUM_WAYS_DEF,
    parameter int TAG_BITS = salc_pkg::TAG_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 q_valid,
    output logic                                 q_ready,
    input  salc_pkg::cls_t                       q_cls,
    input  logic [salc_pkg::idx_w(NUM_SETS)-1:0] q_set,
    input  logic [TAG_BITS-1:0]                  q_tag,
    input  logic [salc_pkg::COST_W-1:0]          hit_time,
    input  logic [salc_pkg::COST_W-1:0]          miss_time,
    output logic                                 r_valid,
    input  logic                                 r_ready,
    output salc_pkg::res_t                       r_res
);
    import salc_pkg::*;

    localparam int SET_W = idx_w(NUM_SETS);
    localparam int WAY_W = idx_w(NUM_WAYS);
    localparam int WB_KEEP = (TAG_BITS < WB_TAG_W) ? TAG_BITS : WB_TAG_W;

    typedef logic [NUM_WAYS-1:0][TAG_BITS-1:0] tag_row_t;
    typedef logic [NUM_WAYS-1:0][WAY_W-1:0]    order_row_t;

    back_state_t state_reg;
    back_state_t state_next;

    tag_row_t            tag_ram_reg [NUM_SETS];
    order_row_t          rec_ram_reg [NUM_SETS];
    tag_row_t            tag_rd_reg;
    order_row_t          rec_rd_reg;
    logic [NUM_WAYS-1:0] vld_reg [NUM_SETS];
    logic [NUM_WAYS-1:0] dirty_reg [NUM_SETS];
    logic [NUM_WAYS-1:0] vld_rd_reg;
    logic [NUM_WAYS-1:0] dirty_rd_reg;

    cls_t                cls_reg;
    logic [SET_W-1:0]    set_reg;
    logic [TAG_BITS-1:0] tag_reg;

    logic [CNT_W-1:0] hits_reg;
    logic [CNT_W-1:0] misses_reg;
    logic [CNT_W-1:0] cevict_reg;
    logic [CNT_W-1:0] devict_reg;
    logic [CNT_W-1:0] hits_next;
    logic [CNT_W-1:0] misses_next;
    logic [CNT_W-1:0] cevict_next;
    logic [CNT_W-1:0] devict_next;

    logic out_valid_reg;
    res_t res_reg;
    res_t res_next;

    logic                pop;
    logic                exec_fire;
    logic                is_fill;
    logic                is_write;
    order_row_t          order;
    order_row_t          order_new;
    logic [NUM_WAYS-1:0] row_vld;
    logic [NUM_WAYS-1:0] row_dirty;
    logic [NUM_WAYS-1:0] match;
    logic [NUM_WAYS-1:0] vld_row_new;
    logic [NUM_WAYS-1:0] dirty_row_new;
    tag_row_t            tag_row_new;
    logic                hit_c;
    logic [WAY_W-1:0]    hpos;
    logic [WAY_W-1:0]    vpos;
    logic [WAY_W-1:0]    sel_pos;
    logic [WAY_W-1:0]    sel_way;
    logic                victim_valid;
    logic                victim_dirty;
    logic                update;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    state_next = B_EXEC;
                end
            end
            B_EXEC: begin
                if (exec_fire) begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb begin
        q_ready = 1'b0;
        exec_fire = 1'b0;
        unique case (state_reg)
            B_IDLE: q_ready = 1'b1;
            B_EXEC: exec_fire = !out_valid_reg || r_ready;
            default: q_ready = 1'b0;
        endcase
    end

    assign pop = q_valid && q_ready;
    assign is_fill = cls_reg.op == OP_FILL;
    assign is_write = cls_reg.op == OP_WRITE;

    // A set without any valid line has never been updated and keeps the reset order.
    always_comb begin
        row_vld = vld_rd_reg;
        row_dirty = dirty_rd_reg;
        for (int k = 0; k < NUM_WAYS; k++) begin
            order[k] = (|row_vld) ? rec_rd_reg[k] : WAY_W'(k);
        end
        for (int w = 0; w < NUM_WAYS; w++) begin
            match[w] = row_vld[w] && (tag_rd_reg[w] == tag_reg);
        end

        hit_c = 1'b0;
        hpos = '0;
        vpos = WAY_W'(NUM_WAYS - 1);
        for (int p = NUM_WAYS - 1; p >= 0; p--) begin
            if (match[order[p]]) begin
                hit_c = !is_fill;
                hpos = WAY_W'(p);
            end
            if (!row_vld[order[p]]) begin
                vpos = WAY_W'(p);
            end
        end
        sel_pos = is_fill ? vpos : hpos;
        sel_way = order[sel_pos];

        order_new = order;
        order_new[0] = sel_way;
        for (int k = 1; k < NUM_WAYS; k++) begin
            if (k <= int'(sel_pos)) begin
                order_new[k] = order[k - 1];
            end
        end

        victim_valid = is_fill && row_vld[sel_way];
        victim_dirty = victim_valid && row_dirty[sel_way];

        tag_row_new = tag_rd_reg;
        tag_row_new[sel_way] = tag_reg;
        vld_row_new = row_vld;
        dirty_row_new = row_dirty;
        if (is_fill) begin
            vld_row_new[sel_way] = 1'b1;
            dirty_row_new[sel_way] = cls_reg.fill_dirty;
        end else if (hit_c && is_write) begin
            dirty_row_new[sel_way] = 1'b1;
        end
        update = is_fill || hit_c;

        hits_next = hits_reg;
        misses_next = misses_reg;
        cevict_next = cevict_reg;
        devict_next = devict_reg;
        if (is_fill) begin
            if (victim_dirty) begin
                devict_next = devict_reg + 1'b1;
            end else if (victim_valid) begin
                cevict_next = cevict_reg + 1'b1;
            end
        end else if (hit_c) begin
            hits_next = hits_reg + 1'b1;
        end else begin
            misses_next = misses_reg + 1'b1;
        end

        res_next.hit = hit_c;
        res_next.writeback_needed = victim_dirty;
        res_next.writeback_tag = '0;
        if (victim_dirty) begin
            for (int b = 0; b < WB_KEEP; b++) begin
                res_next.writeback_tag[b] = tag_rd_reg[sel_way][b];
            end
        end
        res_next.access_cost = update ? hit_time : miss_time;
        res_next.hit_count = hits_next;
        res_next.miss_count = misses_next;
        res_next.clean_evict_count = cevict_next;
        res_next.dirty_evict_count = devict_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            out_valid_reg <= 1'b0;
            hits_reg <= '0;
            misses_reg <= '0;
            cevict_reg <= '0;
            devict_reg <= '0;
            for (int s = 0; s < NUM_SETS; s++) begin
                vld_reg[s] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (exec_fire) begin
                out_valid_reg <= 1'b1;
                hits_reg <= hits_next;
                misses_reg <= misses_next;
                cevict_reg <= cevict_next;
                devict_reg <= devict_next;
                if (update) begin
                    vld_reg[set_reg] <= vld_row_new;
                end
            end else if (r_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cls_reg <= q_cls;
            set_reg <= q_set;
            tag_reg <= q_tag;
            tag_rd_reg <= tag_ram_reg[q_set];
            rec_rd_reg <= rec_ram_reg[q_set];
            vld_rd_reg <= vld_reg[q_set];
            dirty_rd_reg <= dirty_reg[q_set];
        end
        if (exec_fire && is_fill) begin
            tag_ram_reg[set_reg] <= tag_row_new;
        end
        if (exec_fire && update) begin
            rec_ram_reg[set_reg] <= order_new;
            dirty_reg[set_reg] <= dirty_row_new;
        end
        if (exec_fire) begin
            res_reg <= res_next;
        end
    end

    assign r_valid = out_valid_reg;
    assign r_res = res_reg;

    `SALC_ASSERT_NEXT(a_fill_leaves_valid, exec_fire && is_fill, vld_reg[set_reg][$past(sel_way)], "Filled way is not valid.")
    `SALC_ASSERT_NEXT(a_miss_keeps_lines, exec_fire && !is_fill && !hit_c, $stable(vld_reg[set_reg]) && $stable(dirty_reg[set_reg] & vld_reg[set_reg]), "Lookup miss changed the line state.")
    `SALC_ASSERT_NEXT(a_lookup_counted, exec_fire && !is_fill, CNT_W'(hits_reg + misses_reg) == CNT_W'($past(hits_reg + misses_reg) + 1'b1), "Lookup was not counted once.")

endmodule

// File: rtl/core/set_assoc_lru_writeback_cache_tags.sv
// Top level of the set-associative write-back cache tag store with true LRU.
// An accepted item passes the front register, the queue and the back end's read and execute
// states before its result is registered. The back end registers a read of a set's tag and
// recency rows, then updates them, and takes no new item until it is through with the last.
// Synchronous active-low reset clears the valid bits, the counters and the queue at once,
// and sets hit_time to 1 and miss_time to 100.
module set_assoc_lru_writeback_cache_tags #(
    parameter int NUM_SETS = salc_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS = salc_pkg::NUM_WAYS_DEF,
    parameter int TAG_BITS = salc_pkg::TAG_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [salc_pkg::CMD_W-1:0]        s_cmd,
    input  logic [salc_pkg::SET_IN_W-1:0]     s_set_index,
    input  logic [salc_pkg::TAG_IN_W-1:0]     s_tag,
    input  logic                              s_fill_dirty,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_hit,
    output logic                              m_writeback_needed,
    output logic [salc_pkg::WB_TAG_W-1:0]     m_writeback_tag,
    output logic [salc_pkg::COST_W-1:0]       m_access_cost,
    output logic [salc_pkg::CNT_W-1:0]        m_hit_count,
    output logic [salc_pkg::CNT_W-1:0]        m_miss_count,
    output logic [salc_pkg::CNT_W-1:0]        m_clean_evict_count,
    output logic [salc_pkg::CNT_W-1:0]        m_dirty_evict_count,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [salc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [salc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [salc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import salc_pkg::*;

    localparam int SET_W = idx_w(NUM_SETS);
    localparam int QW = $bits(cls_t) + SET_W + TAG_BITS;

    logic [COST_W-1:0] hit_time_reg;
    logic [COST_W-1:0] miss_time_reg;
    logic              cfg_wr;
    logic              reg_sel;

    logic                f_valid;
    logic                f_ready;
    cls_t                f_cls;
    logic [SET_W-1:0]    f_set;
    logic [TAG_BITS-1:0] f_tag;

    logic                q_valid;
    logic                q_ready;
    logic [QW-1:0]       q_data;
    cls_t                q_cls;
    logic [SET_W-1:0]    q_set;
    logic [TAG_BITS-1:0] q_tag;

    res_t res;

    assign pready = 1'b1;
    assign reg_sel = paddr[2];
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_time_reg <= HIT_TIME_RST;
            miss_time_reg <= MISS_TIME_RST;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_HIT_TIME: hit_time_reg <= pwdata[COST_W-1:0];
                REG_MISS_TIME: miss_time_reg <= pwdata[COST_W-1:0];
                default: hit_time_reg <= hit_time_reg;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            REG_HIT_TIME: prdata = APB_DATA_W'(hit_time_reg);
            REG_MISS_TIME: prdata = APB_DATA_W'(miss_time_reg);
            default: prdata = '0;
        endcase
    end

    salc_front #(
        .NUM_SETS(NUM_SETS),
        .TAG_BITS(TAG_BITS)
    ) u_front (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_cmd(s_cmd),
        .s_set_index(s_set_index),
        .s_tag(s_tag),
        .s_fill_dirty(s_fill_dirty),
        .f_valid(f_valid),
        .f_ready(f_ready),
        .f_cls(f_cls),
        .f_set(f_set),
        .f_tag(f_tag)
    );

    salc_queue #(
        .WIDTH(QW)
    ) u_queue (
        .aclk(aclk),
        .aresetn(aresetn),
        .in_valid(f_valid),
        .in_ready(f_ready),
        .in_data({f_cls, f_set, f_tag}),
        .out_valid(q_valid),
        .out_ready(q_ready),
        .out_data(q_data)
    );

    assign {q_cls, q_set, q_tag} = q_data;

    salc_back #(
        .NUM_SETS(NUM_SETS),
        .NUM_WAYS(NUM_WAYS),
        .TAG_BITS(TAG_BITS)
    ) u_back (
        .aclk(aclk),
        .aresetn(aresetn),
        .q_valid(q_valid),
        .q_ready(q_ready),
        .q_cls(q_cls),
        .q_set(q_set),
        .q_tag(q_tag),
        .hit_time(hit_time_reg),
        .miss_time(miss_time_reg),
        .r_valid(m_valid),
        .r_ready(m_ready),
        .r_res(res)
    );

    assign m_hit = res.hit;
    assign m_writeback_needed = res.writeback_needed;
    assign m_writeback_tag = res.writeback_tag;
    assign m_access_cost = res.access_cost;
    assign m_hit_count = res.hit_count;
    assign m_miss_count = res.miss_count;
    assign m_clean_evict_count = res.clean_evict_count;
    assign m_dirty_evict_count = res.dirty_evict_count;

endmodule

// File: verif/cache_tag_checker.sv
`timescale 1ns / 100ps
// Checker that predicts every result beat of the cache tag store and compares it field by field.
module cache_tag_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [salc_pkg::CMD_W-1:0]      s_cmd,
    input  logic [salc_pkg::SET_IN_W-1:0]   s_set_index,
    input  logic [salc_pkg::TAG_IN_W-1:0]   s_tag,
    input  logic                            s_fill_dirty,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic                            m_hit,
    input  logic                            m_writeback_needed,
    input  logic [salc_pkg::WB_TAG_W-1:0]   m_writeback_tag,
    input  logic [salc_pkg::COST_W-1:0]     m_access_cost,
    input  logic [salc_pkg::CNT_W-1:0]      m_hit_count,
    input  logic [salc_pkg::CNT_W-1:0]      m_miss_count,
    input  logic [salc_pkg::CNT_W-1:0]      m_clean_evict_count,
    input  logic [salc_pkg::CNT_W-1:0]      m_dirty_evict_count,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [salc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [salc_pkg::APB_DATA_W-1:0] pwdata,
    output int                              fail_count,
    output int                              pending
);
    import salc_pkg::*;

    localparam int SETS = NUM_SETS_DEF;
    localparam int WAYS = NUM_WAYS_DEF;

    logic [TAG_IN_W-1:0] line_tag [SETS][WAYS];
    bit                  line_vld [SETS][WAYS];
    bit                  line_drt [SETS][WAYS];
    int                  lru_rank [SETS][WAYS];
    logic [CNT_W-1:0]    n_hit;
    logic [CNT_W-1:0]    n_miss;
    logic [CNT_W-1:0]    n_clean;
    logic [CNT_W-1:0]    n_dirty;
    logic [COST_W-1:0]   hit_cost;
    logic [COST_W-1:0]   miss_cost;
    res_t                due_results [$];

    function automatic void promote(int si, int pos);
        int w;
        int k;
        w = lru_rank[si][pos];
        for (k = pos; k > 0; k--) begin
            lru_rank[si][k] = lru_rank[si][k-1];
        end
        lru_rank[si][0] = w;
    endfunction

    function automatic res_t predict_access(op_t op, int si, logic [TAG_IN_W-1:0] tg, logic fd);
        res_t r;
        int   pos;
        int   sel;
        int   way;
        r = '0;
        if (op == OP_FILL) begin
            sel = WAYS - 1;
            for (pos = WAYS - 1; pos >= 0; pos--) begin
                if (!line_vld[si][lru_rank[si][pos]]) begin
                    sel = pos;
                end
            end
            way = lru_rank[si][sel];
            if (line_vld[si][way]) begin
                if (line_drt[si][way]) begin
                    r.writeback_needed = 1'b1;
                    r.writeback_tag = line_tag[si][way];
                    n_dirty = n_dirty + 1;
                end else begin
                    n_clean = n_clean + 1;
                end
            end
            line_tag[si][way] = tg;
            line_vld[si][way] = 1'b1;
            line_drt[si][way] = fd;
            promote(si, sel);
            r.access_cost = hit_cost;
        end else begin
            sel = -1;
            for (pos = WAYS - 1; pos >= 0; pos--) begin
                way = lru_rank[si][pos];
                if (line_vld[si][way] && line_tag[si][way] == tg) begin
                    sel = pos;
                end
            end
            if (sel >= 0) begin
                way = lru_rank[si][sel];
                r.hit = 1'b1;
                n_hit = n_hit + 1;
                if (op == OP_WRITE) begin
                    line_drt[si][way] = 1'b1;
                end
                promote(si, sel);
                r.access_cost = hit_cost;
            end else begin
                n_miss = n_miss + 1;
                r.access_cost = miss_cost;
            end
        end
        r.hit_count = n_hit;
        r.miss_count = n_miss;
        r.clean_evict_count = n_clean;
        r.dirty_evict_count = n_dirty;
        return r;
    endfunction

    function automatic int field_bad(string name, logic [CNT_W-1:0] exp_v, logic [CNT_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin
        res_t want;
        int   bad;
        if (!aresetn) begin
            for (int s = 0; s < SETS; s++) begin
                for (int w = 0; w < WAYS; w++) begin
                    line_tag[s][w] = '0;
                    line_vld[s][w] = 1'b0;
                    line_drt[s][w] = 1'b0;
                    lru_rank[s][w] = w;
                end
            end
            n_hit = '0;
            n_miss = '0;
            n_clean = '0;
            n_dirty = '0;
            hit_cost = HIT_TIME_RST;
            miss_cost = MISS_TIME_RST;
            due_results.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[APB_ADDR_W-1:2] == REG_HIT_TIME) begin
                    hit_cost = pwdata[COST_W-1:0];
                end else if (paddr[APB_ADDR_W-1:2] == REG_MISS_TIME) begin
                    miss_cost = pwdata[COST_W-1:0];
                end
            end
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    $error("Result beat arrived with no expected result pending.");
                    fail_count++;
                end else begin
                    want = due_results.pop_front();
                    bad = 0;
                    bad += field_bad("hit", want.hit, m_hit);
                    bad += field_bad("writeback_needed", want.writeback_needed, m_writeback_needed);
                    bad += field_bad("writeback_tag", want.writeback_tag, m_writeback_tag);
                    bad += field_bad("access_cost", want.access_cost, m_access_cost);
                    bad += field_bad("hit_count", want.hit_count, m_hit_count);
                    bad += field_bad("miss_count", want.miss_count, m_miss_count);
                    bad += field_bad("clean_evict_count", want.clean_evict_count,
                                     m_clean_evict_count);
                    bad += field_bad("dirty_evict_count", want.dirty_evict_count,
                                     m_dirty_evict_count);
                    if (bad != 0) begin
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                due_results.push_back(predict_access(op_t'(s_cmd), int'(s_set_index) % SETS,
                                                     s_tag, s_fill_dirty));
            end
        end
        pending = due_results.size();
    end

endmodule

// File: verif/tb_set_assoc_lru_writeback_cache_tags.sv
`timescale 1ns / 100ps
// Top of the cache tag store testbench: clock, reset, stimulus, register writes and verdict.
module tb_set_assoc_lru_writeback_cache_tags;
    import salc_pkg::*;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [CMD_W-1:0]      s_cmd;
    logic [SET_IN_W-1:0]   s_set_index;
    logic [TAG_IN_W-1:0]   s_tag;
    logic                  s_fill_dirty;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_hit;
    logic                  m_writeback_needed;
    logic [WB_TAG_W-1:0]   m_writeback_tag;
    logic [COST_W-1:0]     m_access_cost;
    logic [CNT_W-1:0]      m_hit_count;
    logic [CNT_W-1:0]      m_miss_count;
    logic [CNT_W-1:0]      m_clean_evict_count;
    logic [CNT_W-1:0]      m_dirty_evict_count;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    fail_count;
    int                    pending;
    int                    burst_left;
    int                    results_taken;

    logic [TAG_IN_W-1:0] tag_pool [6] = '{20'h00000, 20'hFFFFF, 20'hA5A5A,
                                          20'h5A5A5, 20'h00001, 20'h80000};

    set_assoc_lru_writeback_cache_tags u_top (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_cmd               (s_cmd),
        .s_set_index         (s_set_index),
        .s_tag               (s_tag),
        .s_fill_dirty        (s_fill_dirty),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_hit               (m_hit),
        .m_writeback_needed  (m_writeback_needed),
        .m_writeback_tag     (m_writeback_tag),
        .m_access_cost       (m_access_cost),
        .m_hit_count         (m_hit_count),
        .m_miss_count        (m_miss_count),
        .m_clean_evict_count (m_clean_evict_count),
        .m_dirty_evict_count (m_dirty_evict_count),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    cache_tag_checker u_checker (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_cmd               (s_cmd),
        .s_set_index         (s_set_index),
        .s_tag               (s_tag),
        .s_fill_dirty        (s_fill_dirty),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_hit               (m_hit),
        .m_writeback_needed  (m_writeback_needed),
        .m_writeback_tag     (m_writeback_tag),
        .m_access_cost       (m_access_cost),
        .m_hit_count         (m_hit_count),
        .m_miss_count        (m_miss_count),
        .m_clean_evict_count (m_clean_evict_count),
        .m_dirty_evict_count (m_dirty_evict_count),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .pready              (pready),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .fail_count          (fail_count),
        .pending             (pending)
    );

    initial begin
        aclk = 1'b0;
        forever begin
            #6 aclk = ~aclk;
        end
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            results_taken++;
        end
    end

    task automatic offer(op_t op, logic [SET_IN_W-1:0] si, logic [TAG_IN_W-1:0] tg, logic fd);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                @(negedge aclk) s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 16);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_cmd <= op;
        s_set_index <= si;
        s_tag <= tg;
        s_fill_dirty <= fd;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
    endtask

    task automatic cfg_write(logic reg_sel, logic [COST_W-1:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {reg_sel, 2'b00};
        pwdata <= {16'($urandom), value};
        @(negedge aclk) penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic settle_idle();
        @(negedge aclk) s_valid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic run_random(int count);
        op_t                 op;
        logic [SET_IN_W-1:0] si;
        logic [TAG_IN_W-1:0] tg;
        for (int i = 0; i < count; i++) begin
            op = ($urandom_range(0, 99) < 35) ? OP_FILL : op_t'($urandom_range(0, 2));
            si = ($urandom_range(0, 99) < 75) ? SET_IN_W'($urandom_range(0, 7))
                                               : SET_IN_W'($urandom_range(0, 63));
            tg = ($urandom_range(0, 99) < 80) ? tag_pool[$urandom_range(0, 5)]
                                               : TAG_IN_W'($urandom);
            offer(op, si, tg, 1'($urandom));
        end
    endtask

    initial begin : receiver
        int mode;
        int span;
        bit held;
        m_ready = 1'b0;
        held = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 60);
            repeat (span) begin
                @(negedge aclk);
                if (!held && results_taken >= 300) begin
                    held = 1'b1;
                    m_ready <= 1'b0;
                    repeat (500) @(negedge aclk);
                end
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_cmd = OP_READ;
        s_set_index = '0;
        s_tag = '0;
        s_fill_dirty = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        burst_left = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        cfg_write(REG_HIT_TIME, 16'h0000);
        cfg_write(REG_MISS_TIME, 16'hFFFF);

        offer(OP_READ,  6'd0,  20'h00000, 1'b1);
        offer(OP_FILL,  6'd0,  20'h00000, 1'b0);
        offer(OP_FILL,  6'd0,  20'hFFFFF, 1'b1);
        offer(OP_FILL,  6'd0,  20'hA5A5A, 1'b0);
        offer(OP_FILL,  6'd0,  20'h00000, 1'b1);
        offer(OP_READ,  6'd0,  20'h00000, 1'b0);
        offer(OP_WRITE, 6'd0,  20'hA5A5A, 1'b0);
        offer(OP_FETCH, 6'd0,  20'hFFFFF, 1'b1);
        offer(OP_FETCH, 6'd0,  20'h12345, 1'b0);
        offer(OP_WRITE, 6'd0,  20'h54321, 1'b1);
        offer(OP_FILL,  6'd0,  20'h11111, 1'b0);
        offer(OP_FILL,  6'd0,  20'h22222, 1'b1);
        offer(OP_FILL,  6'd0,  20'h33333, 1'b0);
        offer(OP_FILL,  6'd0,  20'h44444, 1'b0);
        offer(OP_FILL,  6'd0,  20'h55555, 1'b0);
        offer(OP_FILL,  6'd63, 20'hFFFFF, 1'b0);
        offer(OP_WRITE, 6'd63, 20'hFFFFF, 1'b0);
        offer(OP_READ,  6'd63, 20'hFFFFF, 1'b0);
        offer(OP_FILL,  6'd63, 20'h00000, 1'b1);
        offer(OP_FILL,  6'd63, 20'h5A5A5, 1'b0);
        offer(OP_FILL,  6'd63, 20'h80000, 1'b0);
        offer(OP_FETCH, 6'd63, 20'hFFFFF, 1'b0);
        offer(OP_FILL,  6'd63, 20'h00001, 1'b0);
        offer(OP_FILL,  6'd63, 20'h00002, 1'b0);
        offer(OP_READ,  6'd63, 20'h00000, 1'b0);

        run_random(400);
        settle_idle();
        cfg_write(REG_HIT_TIME, 16'hFFFF);
        cfg_write(REG_MISS_TIME, 16'h0000);
        run_random(400);
        settle_idle();
        cfg_write(REG_HIT_TIME, 16'($urandom));
        cfg_write(REG_MISS_TIME, 16'($urandom));
        run_random(400);
        settle_idle();
        cfg_write(REG_HIT_TIME, HIT_TIME_RST);
        cfg_write(REG_MISS_TIME, MISS_TIME_RST);
        run_random(300);
        settle_idle();

        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/salc_pkg.sv
rtl/core/salc_front.sv
rtl/core/salc_queue.sv
rtl/core/salc_back.sv
rtl/core/set_assoc_lru_writeback_cache_tags.sv
verif/cache_tag_checker.sv
verif/tb_set_assoc_lru_writeback_cache_tags.sv
